// File: hdl/bscpn_pkg.sv
package bscpn_pkg;

  // Q16.16 coordinate width and axis count
  localparam int unsigned CoordW = 32;
  localparam int unsigned NumAxes = 3;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_X = 3'd0;
  localparam logic [2:0] CFG_MIN_Y = 3'd1;
  localparam logic [2:0] CFG_MIN_Z = 3'd2;
  localparam logic [2:0] CFG_MAX_X = 3'd3;
  localparam logic [2:0] CFG_MAX_Y = 3'd4;
  localparam logic [2:0] CFG_MAX_Z = 3'd5;

  // box reset corners: 0.0 and 1.0
  localparam logic [CoordW-1:0] BoxMinReset = 32'h0000_0000;
  localparam logic [CoordW-1:0] BoxMaxReset = 32'h0001_0000;

  // outward face codes, in tie-break order
  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_PY = 3'd1,
    FACE_PZ = 3'd2,
    FACE_NX = 3'd3,
    FACE_NY = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  // x in [0], y in [1], z in [2]
  typedef logic [NumAxes-1:0][CoordW-1:0] vec_t;

  typedef struct packed {
    vec_t  near;
    face_t face;
    logic  was_inside;
  } res_t;

endpackage

// File: hdl/bscpn_inside.sv
// Inside case: nearest face by absolute distance, then projection onto it.
// Also decides whether the point lies within the box at all.
module bscpn_inside (
  input  bscpn_pkg::vec_t q,
  input  bscpn_pkg::vec_t box_min,
  input  bscpn_pkg::vec_t box_max,
  output bscpn_pkg::res_t res
);

  logic signed [32:0] d [6];
  logic [2:0] in_axis;
  logic signed [32:0] da, db, dc, dd;
  bscpn_pkg::face_t fa, fb, fc, fd, fe;

  // distances to the six faces, exact in 33 bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d[a]   = $signed({box_max[a][31], box_max[a]}) - $signed({q[a][31], q[a]});
      d[a+3] = $signed({q[a][31], q[a]}) - $signed({box_min[a][31], box_min[a]});
      in_axis[a] = ($signed(q[a]) >= $signed(box_min[a])) &&
                   ($signed(q[a]) <= $signed(box_max[a]));
    end
  end

  // minimum tree; the later face wins only when strictly nearer
  always_comb begin
    if (d[1] < d[0]) begin
      da = d[1]; fa = bscpn_pkg::FACE_PY;
    end else begin
      da = d[0]; fa = bscpn_pkg::FACE_PX;
    end
    if (d[3] < d[2]) begin
      db = d[3]; fb = bscpn_pkg::FACE_NX;
    end else begin
      db = d[2]; fb = bscpn_pkg::FACE_PZ;
    end
    if (d[5] < d[4]) begin
      dc = d[5]; fc = bscpn_pkg::FACE_NZ;
    end else begin
      dc = d[4]; fc = bscpn_pkg::FACE_NY;
    end
    if (db < da) begin
      dd = db; fd = fb;
    end else begin
      dd = da; fd = fa;
    end
    fe = (dc < dd) ? fc : fd;
  end

  // project onto the chosen face
  always_comb begin
    res.near       = q;
    res.face       = fe;
    res.was_inside = &in_axis;
    unique case (fe)
      bscpn_pkg::FACE_PX: res.near[0] = box_max[0];
      bscpn_pkg::FACE_PY: res.near[1] = box_max[1];
      bscpn_pkg::FACE_PZ: res.near[2] = box_max[2];
      bscpn_pkg::FACE_NX: res.near[0] = box_min[0];
      bscpn_pkg::FACE_NY: res.near[1] = box_min[1];
      bscpn_pkg::FACE_NZ: res.near[2] = box_min[2];
      default:            res.near    = q;
    endcase
  end

endmodule

// File: hdl/bscpn_outside.sv
// Outside case: clamp to the box, then the face whose normal best matches
// the offset from the clamped point to the query.
module bscpn_outside (
  input  bscpn_pkg::vec_t q,
  input  bscpn_pkg::vec_t box_min,
  input  bscpn_pkg::vec_t box_max,
  output bscpn_pkg::res_t res
);

  bscpn_pkg::vec_t p;
  logic signed [33:0] v [6];
  logic signed [33:0] va, vb, vc, vd;
  bscpn_pkg::face_t fa, fb, fc, fd, fe;

  // clamp per axis and form the signed offsets for both normals
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if ($signed(q[a]) < $signed(box_min[a])) begin
        p[a] = box_min[a];
      end else if ($signed(q[a]) > $signed(box_max[a])) begin
        p[a] = box_max[a];
      end else begin
        p[a] = q[a];
      end
      v[a]   = $signed({{2{q[a][31]}}, q[a]}) - $signed({{2{p[a][31]}}, p[a]});
      v[a+3] = -v[a];
    end
  end

  // maximum tree; the later face wins only when strictly larger
  always_comb begin
    if (v[1] > v[0]) begin
      va = v[1]; fa = bscpn_pkg::FACE_PY;
    end else begin
      va = v[0]; fa = bscpn_pkg::FACE_PX;
    end
    if (v[3] > v[2]) begin
      vb = v[3]; fb = bscpn_pkg::FACE_NX;
    end else begin
      vb = v[2]; fb = bscpn_pkg::FACE_PZ;
    end
    if (v[5] > v[4]) begin
      vc = v[5]; fc = bscpn_pkg::FACE_NZ;
    end else begin
      vc = v[4]; fc = bscpn_pkg::FACE_NY;
    end
    if (vb > va) begin
      vd = vb; fd = fb;
    end else begin
      vd = va; fd = fa;
    end
    fe = (vc > vd) ? fc : fd;
  end

  assign res.near       = p;
  assign res.face       = fe;
  assign res.was_inside = 1'b0;

endmodule

// File: hdl/box_surface_closest_point_normal.sv
// channel   direction  handshake          payload
// in_*      input      in_valid/in_stall  query_x, query_y, query_z (Q16.16)
// out_*     output     out_valid/out_stall near_x/y/z, face_index, was_inside
// cfg_*     input      cfg_we             cfg_index (0..5), cfg_data
//
// One request per cycle sustained while out_stall is low; each request passes
// the input register, then the face trees and clamp, then the result register.
// rst_n is synchronous; it clears the valids and returns the box to [0,1]^3.
// out_stall holds the result register; the input register still takes a
// request while it is empty, or the result register is empty or being drained.
module box_surface_closest_point_normal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_query_x,
  input  logic [31:0] in_query_y,
  input  logic [31:0] in_query_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_near_x,
  output logic [31:0] out_near_y,
  output logic [31:0] out_near_z,
  output logic [2:0]  out_face_index,
  output logic        out_was_inside
);

  bscpn_pkg::vec_t box_min_r, box_max_r;
  bscpn_pkg::vec_t s1_q_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  bscpn_pkg::res_t res_r, res_nxt;
  bscpn_pkg::res_t in_res, out_res;
  logic            s1_adv, s2_adv;

  // box corner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= {3{bscpn_pkg::BoxMinReset}};
      box_max_r <= {3{bscpn_pkg::BoxMaxReset}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        bscpn_pkg::CFG_MIN_X: box_min_r[0] <= cfg_data;
        bscpn_pkg::CFG_MIN_Y: box_min_r[1] <= cfg_data;
        bscpn_pkg::CFG_MIN_Z: box_min_r[2] <= cfg_data;
        bscpn_pkg::CFG_MAX_X: box_max_r[0] <= cfg_data;
        bscpn_pkg::CFG_MAX_Y: box_max_r[1] <= cfg_data;
        bscpn_pkg::CFG_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign s2_adv   = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_q_r <= {in_query_z, in_query_y, in_query_x};
    end
  end

  bscpn_inside u_inside (
    .q       (s1_q_r),
    .box_min (box_min_r),
    .box_max (box_max_r),
    .res     (in_res)
  );

  bscpn_outside u_outside (
    .q       (s1_q_r),
    .box_min (box_min_r),
    .box_max (box_max_r),
    .res     (out_res)
  );

  assign res_nxt = in_res.was_inside ? in_res : out_res;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_near_x     = res_r.near[0];
  assign out_near_y     = res_r.near[1];
  assign out_near_z     = res_r.near[2];
  assign out_face_index = res_r.face;
  assign out_was_inside = res_r.was_inside;

  // a request in the input register moves on when the result side is free
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_adv |=> out_valid_r)
    else $error("input register request not moved to result register");

  // an empty input register never stalls the input side
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  // an inside result sits on the bound of its chosen face
  a_inside_on_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_was_inside |->
      ((res_r.face == bscpn_pkg::FACE_PX && out_near_x == box_max_r[0]) ||
       (res_r.face == bscpn_pkg::FACE_PY && out_near_y == box_max_r[1]) ||
       (res_r.face == bscpn_pkg::FACE_PZ && out_near_z == box_max_r[2]) ||
       (res_r.face == bscpn_pkg::FACE_NX && out_near_x == box_min_r[0]) ||
       (res_r.face == bscpn_pkg::FACE_NY && out_near_y == box_min_r[1]) ||
       (res_r.face == bscpn_pkg::FACE_NZ && out_near_z == box_min_r[2])))
    else $error("inside result not on its face");

endmodule
